>>> rtl/core/vnu_pkg.sv
// vnu_pkg: widths, constants and the inter-stage word type of the vector
// normalize unit. Used by every file in rtl/core; depends on nothing.
package vnu_pkg;

    localparam int COMP_BITS = 16;                 // component width, 8..32
    localparam int UNIT_BITS = 16;                 // Q1.14 output width
    localparam int WBITS     = 16;                 // bits of floor(2*u), up to 2^15
    localparam int FRAC_SH   = 30;                 // a^2 is scaled by 2^30
    localparam int SUM_W     = 2 * COMP_BITS;      // x^2+y^2+z^2
    localparam int RS_W      = SUM_W + 1;          // square root trial / residual
    localparam int RES_W     = 2 * COMP_BITS + 34; // unit residual and trial
    localparam int Q_W       = SUM_W + WBITS;      // w * S
    localparam int NSTEP     = (COMP_BITS > WBITS) ? COMP_BITS : WBITS;
    localparam logic [UNIT_BITS-1:0] UNIT_ONE = UNIT_BITS'(16384);

    typedef struct packed {
        logic [SUM_W-1:0]             s;
        logic [COMP_BITS-1:0]         root;
        logic [RS_W-1:0]              rs;
        logic [2:0][RES_W-1:0]        r;
        logic [2:0][Q_W-1:0]          q;
        logic [2:0][WBITS-1:0]        w;
        logic [2:0]                   neg;
        logic                         zero;
    } iter_t;

endpackage

>>> rtl/core/vnu_front.sv
// vnu_front: magnitude, squaring and sum stages (three registers).
// Depends on vnu_pkg.
module vnu_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [vnu_pkg::COMP_BITS-1:0] x,
    input  logic signed [vnu_pkg::COMP_BITS-1:0] y,
    input  logic signed [vnu_pkg::COMP_BITS-1:0] z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output vnu_pkg::iter_t                 out_data
);
    localparam int CB = vnu_pkg::COMP_BITS;

    logic [2:0] v_reg;
    logic [2:0] en;
    logic [2:0][CB-1:0]   mag_reg, mag_next;
    logic [2:0]           neg_a_reg, neg_a_next, neg_b_reg;
    logic [2:0][2*CB-1:0] sq_reg;
    vnu_pkg::iter_t       data_reg, data_next;
    logic [2:0][CB-1:0]   comp;

    assign en[2] = !v_reg[2] || out_ready;
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];
    assign out_data  = data_reg;

    assign comp[0] = x;
    assign comp[1] = y;
    assign comp[2] = z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_a_next[i] = comp[i][CB-1];
            mag_next[i]   = comp[i][CB-1] ? (~comp[i] + CB'(1)) : comp[i];
        end
    end

    always_comb begin
        logic [vnu_pkg::SUM_W-1:0] s;
        s = vnu_pkg::SUM_W'(sq_reg[0]) + vnu_pkg::SUM_W'(sq_reg[1])
          + vnu_pkg::SUM_W'(sq_reg[2]);
        data_next      = '0;
        data_next.s    = s;
        data_next.rs   = vnu_pkg::RS_W'(s);
        data_next.neg  = neg_b_reg;
        data_next.zero = (s == '0);
        for (int i = 0; i < 3; i++) begin
            data_next.r[i] = vnu_pkg::RES_W'(sq_reg[i]) << vnu_pkg::FRAC_SH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mag_reg   <= mag_next;
            neg_a_reg <= neg_a_next;
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
            neg_b_reg <= neg_a_reg;
        end
        if (en[2]) data_reg <= data_next;
    end
endmodule

>>> rtl/core/vnu_iter.sv
// vnu_iter: digit-by-digit stages, one bit of the length and one bit of each
// doubled unit component per register. Depends on vnu_pkg.
module vnu_iter (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vnu_pkg::iter_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vnu_pkg::iter_t out_data
);
    localparam int N = vnu_pkg::NSTEP;

    logic [N-1:0]   v_reg;
    logic [N-1:0]   en;
    vnu_pkg::iter_t st_reg  [N];
    vnu_pkg::iter_t st_next [N];

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_data  = st_reg[N-1];

    for (genvar j = 0; j < N; j++) begin : g_step
        localparam int K = N - 1 - j;
        vnu_pkg::iter_t d;

        if (j == 0) begin : g_first
            assign d = in_data;
        end else begin : g_chain
            assign d = st_reg[j-1];
        end

        if (j == N - 1) begin : g_last
            assign en[j] = !v_reg[j] || out_ready;
        end else begin : g_mid
            assign en[j] = !v_reg[j] || en[j+1];
        end

        always_comb begin
            logic [vnu_pkg::RS_W-1:0]  t_s;
            logic [vnu_pkg::RES_W-1:0] t_u;
            st_next[j] = d;
            t_s = '0;
            t_u = '0;
            if (K < vnu_pkg::COMP_BITS) begin
                // trial: (root + 2^K)^2 - root^2
                t_s = (vnu_pkg::RS_W'(d.root) << (K + 1))
                    + (vnu_pkg::RS_W'(1) << (2 * K));
                if (t_s <= d.rs) begin
                    st_next[j].rs = d.rs - t_s;
                    st_next[j].root[K % vnu_pkg::COMP_BITS] = 1'b1;
                end
            end
            if (K < vnu_pkg::WBITS) begin
                // largest w with w^2 * S <= a^2 * 2^30; q tracks w * S
                for (int c = 0; c < 3; c++) begin
                    t_u = (vnu_pkg::RES_W'(d.q[c]) << (K + 1))
                        + (vnu_pkg::RES_W'(d.s) << (2 * K));
                    if (t_u <= d.r[c]) begin
                        st_next[j].r[c] = d.r[c] - t_u;
                        st_next[j].q[c] = d.q[c] + (vnu_pkg::Q_W'(d.s) << K);
                        st_next[j].w[c][K % vnu_pkg::WBITS] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en[j]) begin
                v_reg[j] <= (j == 0) ? in_valid : v_reg[(j == 0) ? 0 : j - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[j]) st_reg[j] <= st_next[j];
        end
    end
endmodule

>>> rtl/core/vnu_back.sv
// vnu_back: rounding, sign and zero handling into the output register.
// Depends on vnu_pkg.
module vnu_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  vnu_pkg::iter_t                       in_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [vnu_pkg::COMP_BITS-1:0]        m_length,
    output logic signed [vnu_pkg::UNIT_BITS-1:0] m_unit_x,
    output logic signed [vnu_pkg::UNIT_BITS-1:0] m_unit_y,
    output logic signed [vnu_pkg::UNIT_BITS-1:0] m_unit_z,
    output logic                                 m_zero_vector
);
    localparam int UB = vnu_pkg::UNIT_BITS;

    logic                          v_reg;
    logic                          en;
    logic [vnu_pkg::COMP_BITS-1:0] len_reg;
    logic [2:0][UB-1:0]            unit_reg, unit_next;
    logic                          zero_reg;

    assign en       = !v_reg || m_ready;
    assign in_ready = en;

    always_comb begin
        logic [vnu_pkg::WBITS:0] w1;
        logic [UB-1:0]           mag;
        for (int c = 0; c < 3; c++) begin
            // w = floor(2u); rounded u is (w + 1) / 2
            w1  = {1'b0, in_data.w[c]} + 1'b1;
            mag = UB'(w1 >> 1);
            if (mag > vnu_pkg::UNIT_ONE) mag = vnu_pkg::UNIT_ONE;
            if (in_data.zero) begin
                unit_next[c] = '0;
            end else begin
                unit_next[c] = in_data.neg[c] ? (~mag + UB'(1)) : mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg  <= in_data.root;
            unit_reg <= unit_next;
            zero_reg <= in_data.zero;
        end
    end

    assign m_valid       = v_reg;
    assign m_length      = len_reg;
    assign m_unit_x      = unit_reg[0];
    assign m_unit_y      = unit_reg[1];
    assign m_unit_z      = unit_reg[2];
    assign m_zero_vector = zero_reg;
endmodule

>>> rtl/core/vector3_normalize_unit.sv
// Vector normalize unit: takes one signed Q4.12 3D vector per cycle and returns
// its length (floor of the square root of x^2+y^2+z^2) and its unit vector in
// Q1.14, rounded to nearest, ties away from zero. A zero vector sets
// zero_vector and returns zeros. Sustained rate is one word per cycle when the
// output is not stalled. There are 3 front stages, 16 digit stages and 1 output
// register; digit stages give one square root and unit-component bit each.
// Every stage has its own valid bit, so bubbles close up under back-pressure.
// Depends on vnu_pkg, vnu_front, vnu_iter, vnu_back.
module vector3_normalize_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [vnu_pkg::COMP_BITS-1:0] s_x,
    input  logic signed [vnu_pkg::COMP_BITS-1:0] s_y,
    input  logic signed [vnu_pkg::COMP_BITS-1:0] s_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [vnu_pkg::COMP_BITS-1:0]        m_length,
    output logic signed [vnu_pkg::UNIT_BITS-1:0] m_unit_x,
    output logic signed [vnu_pkg::UNIT_BITS-1:0] m_unit_y,
    output logic signed [vnu_pkg::UNIT_BITS-1:0] m_unit_z,
    output logic                                 m_zero_vector
);
    logic           f_valid, f_ready;
    logic           i_valid, i_ready;
    vnu_pkg::iter_t f_data, i_data;

    vnu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x         (s_x),
        .y         (s_y),
        .z         (s_z),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    vnu_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (i_valid),
        .out_ready (i_ready),
        .out_data  (i_data)
    );

    vnu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (i_valid),
        .in_ready      (i_ready),
        .in_data       (i_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_length      (m_length),
        .m_unit_x      (m_unit_x),
        .m_unit_y      (m_unit_y),
        .m_unit_z      (m_unit_z),
        .m_zero_vector (m_zero_vector)
    );

`ifndef NO_ASSERTIONS
    // an empty output register lets the whole pipe advance
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_vector |->
            m_length == '0 && m_unit_x == '0 && m_unit_y == '0 && m_unit_z == '0)
        else $error("zero vector word not cleared");

    a_nonzero_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_zero_vector |-> m_length != '0)
        else $error("nonzero vector with zero length");

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_unit_x <= $signed(vnu_pkg::UNIT_ONE)
                 && m_unit_x >= -$signed(vnu_pkg::UNIT_ONE)
                 && m_unit_y <= $signed(vnu_pkg::UNIT_ONE)
                 && m_unit_y >= -$signed(vnu_pkg::UNIT_ONE)
                 && m_unit_z <= $signed(vnu_pkg::UNIT_ONE)
                 && m_unit_z >= -$signed(vnu_pkg::UNIT_ONE))
        else $error("unit component out of range");
`endif
endmodule

>>> tb/vector3_normalize_unit_tb.sv
// Self-checking testbench for vector3_normalize_unit: random and directed vectors,
// predicted length and rounded unit vector compared word by word.
// Depends on vnu_pkg and the vector3_normalize_unit RTL.
`timescale 1ns / 1ps

module vector3_normalize_unit_tb;
    localparam int CB = vnu_pkg::COMP_BITS;
    localparam int UB = vnu_pkg::UNIT_BITS;

    typedef struct {
        logic [CB-1:0] x, y, z;
    } vec_t;

    typedef struct {
        logic [CB-1:0] length;
        logic [UB-1:0] ux, uy, uz;
        logic          zero;
    } norm_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    logic signed [CB-1:0] s_x = 0, s_y = 0, s_z = 0;
    logic [CB-1:0] m_length;
    logic signed [UB-1:0] m_unit_x, m_unit_y, m_unit_z;
    logic m_zero_vector;

    vec_t  pending_vecs[$];
    norm_t expected_norms[$];
    int    errors = 0, words_in = 0, words_out = 0, zero_seen = 0;
    int    cycles = 0;
    bit    quiet = 0, hold_req = 0;
    int    send_gap = 0, recv_gap = 0, hold_cnt = 0;

    // accepted-at-posedge flag for the driver
    logic s_ready_q = 0;

    vector3_normalize_unit dut (.*);

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) s_ready_q <= s_ready;

    function automatic logic [63:0] isqrt(input logic [63:0] s);
        logic [63:0] res, b;
        res = '0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // largest u with (2u-1)^2 * s <= a^2 * 2^30, i.e. round(a*2^14/sqrt(s))
    function automatic logic [15:0] unit_mag(input logic [63:0] a, input logic [63:0] s);
        logic [63:0] lo, hi, mid, t;
        logic [127:0] lhs, rhs;
        lo = '0;
        hi = 64'd16384;
        rhs = 128'(a * a) << 30;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            t = 64'd2 * mid - 64'd1;
            lhs = 128'(t * t) * 128'(s);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 64'd1;
        end
        return lo[15:0];
    endfunction

    function automatic norm_t normalize(input vec_t v);
        norm_t r;
        logic [63:0] m[3], s;
        logic neg[3];
        logic [CB-1:0] c[3];
        logic [15:0] u;
        c[0] = v.x; c[1] = v.y; c[2] = v.z;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i][CB-1];
            m[i] = neg[i] ? 64'(-c[i]) & ((64'd1 << CB) - 64'd1) : 64'(c[i]);
            if (neg[i] && m[i] == 0) m[i] = 64'd1 << CB;
            s += m[i] * m[i];
        end
        r = '{default: 0};
        if (s == 0) begin
            r.zero = 1;
            return r;
        end
        r.length = CB'(isqrt(s));
        for (int i = 0; i < 3; i++) begin
            u = unit_mag(m[i], s);
            if (neg[i]) u = -u;
            if (i == 0) r.ux = u;
            else if (i == 1) r.uy = u;
            else r.uz = u;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch word %0d %s: got %0h want %0h", words_out, what, got, want);
    endtask

    function automatic logic [CB-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return CB'($urandom_range(0, 8)) - CB'(4);
            1: return $urandom_range(0, 1) ? {1'b1, {(CB-1){1'b0}}}
                                           : {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom_range(0, 64)) - CB'(32);
            default: return CB'($urandom);
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_q) begin
                pending_vecs.pop_front();
                words_in++;
            end
            if (!(s_valid && !s_ready_q)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 0;
                end else if (pending_vecs.size() > 0) begin
                    s_valid <= 1;
                    s_x <= pending_vecs[0].x;
                    s_y <= pending_vecs[0].y;
                    s_z <= pending_vecs[0].z;
                    if (!quiet && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 19);
                end else begin
                    s_valid <= 0;
                end
            end
            // receiver
            if (hold_req) begin
                m_ready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                if (!quiet && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 19);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        norm_t e;
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready)
            expected_norms.push_back(normalize('{s_x, s_y, s_z}));
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (expected_norms.size() == 0) begin
                report("unexpected", 32'd0, 32'd0);
            end else begin
                e = expected_norms.pop_front();
                if (m_zero_vector) zero_seen++;
                if (m_length !== e.length)
                    report("length", 32'(m_length), 32'(e.length));
                if (m_unit_x !== e.ux) report("unit_x", 32'(m_unit_x), 32'(e.ux));
                if (m_unit_y !== e.uy) report("unit_y", 32'(m_unit_y), 32'(e.uy));
                if (m_unit_z !== e.uz) report("unit_z", 32'(m_unit_z), 32'(e.uz));
                if (m_zero_vector !== e.zero)
                    report("zero_vector", 32'(m_zero_vector), 32'(e.zero));
            end
        end
    end

    // long receiver hold-off to back the pipeline up into the input
    initial begin
        wait (words_in >= 300);
        @(negedge aclk);
        hold_req = 1;
        hold_cnt = 0;
        while (hold_cnt < 200) begin
            @(posedge aclk);
            hold_cnt++;
        end
        @(negedge aclk);
        hold_req = 0;
    end

    initial begin
        logic [CB-1:0] mx, mn;
        int total;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        pending_vecs.push_back('{'0, '0, '0});
        pending_vecs.push_back('{mx, mx, mx});
        pending_vecs.push_back('{mn, mn, mn});
        pending_vecs.push_back('{mn, '0, '0});
        pending_vecs.push_back('{'0, mx, '0});
        pending_vecs.push_back('{'0, '0, mn});
        pending_vecs.push_back('{CB'(1), '0, '0});
        pending_vecs.push_back('{'0, CB'(-1), '0});
        pending_vecs.push_back('{CB'(1), CB'(1), CB'(1)});
        pending_vecs.push_back('{CB'(3), CB'(4), '0});        // exact length
        pending_vecs.push_back('{CB'(-3), '0, CB'(4)});
        pending_vecs.push_back('{CB'(1), CB'(1), '0});
        pending_vecs.push_back('{mx, mn, CB'(1)});
        pending_vecs.push_back('{CB'(-1), CB'(-1), CB'(-1)});
        pending_vecs.push_back('{CB'(16'h1000), CB'(16'h1000), CB'(16'h1000)});
        pending_vecs.push_back('{'0, '0, '0});
        total = 1650;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        for (int i = 0; i < total; i++) begin
            if (i == total - 200) quiet = 1;
            if (i == 900) pending_vecs.push_back('{'0, '0, '0});
            else pending_vecs.push_back('{rand_comp(), rand_comp(), rand_comp()});
            while (pending_vecs.size() > 8) @(posedge aclk);
        end
        while (pending_vecs.size() > 0 || s_valid) @(posedge aclk);
        while (expected_norms.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("%0d vectors sent, %0d results checked, %0d zero vectors, with stalls",
                 words_in, words_out, zero_seen);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        wait (cycles >= 400000);
        $display("status: fail");
        $finish;
    end
endmodule

>>> files.f
rtl/core/vnu_pkg.sv
rtl/core/vnu_front.sv
rtl/core/vnu_iter.sv
rtl/core/vnu_back.sv
rtl/core/vector3_normalize_unit.sv
tb/vector3_normalize_unit_tb.sv
